### rtl/ictf_pkg.sv
// Shared types, format constants and helpers for the integer to IEEE 754 converter.
// No dependencies.
package ictf_pkg;

  localparam int ValueW   = 64;
  localparam int LeadW    = 6;
  localparam int SglMant  = 23;
  localparam int SglExpW  = 8;
  localparam int SglBias  = 127;
  localparam int SglW     = 32;
  localparam int DblMant  = 52;
  localparam int DblExpW  = 11;
  localparam int DblBias  = 1023;

  typedef enum logic [1:0] {
    MODE_I32_SGL = 2'd0,
    MODE_I32_DBL = 2'd1,
    MODE_I64_SGL = 2'd2,
    MODE_I64_DBL = 2'd3
  } mode_t;

  // magnitude word passed from the normalize stage to the round stage
  typedef struct packed {
    logic                 dbl;
    logic                 trunc;
    logic                 neg;
    logic                 zero;
    logic [LeadW-1:0]     lead;
    logic [ValueW-1:0]    mag;
  } norm_t;

  // position of the highest set bit, 0 for an all-zero word
  function automatic logic [LeadW-1:0] lead_one(input logic [ValueW-1:0] m);
    logic [LeadW-1:0] p;
    p = '0;
    for (int i = 0; i < ValueW; i++) begin
      if (m[i]) begin
        p = LeadW'(i);
      end
    end
    return p;
  endfunction

endpackage

### rtl/int_to_float_convert.sv
// Top level: signed 32/64-bit integer to IEEE 754 single or double.
// Depends on ictf_pkg, ictf_norm, ictf_round.
// Pipeline: a start word passes the input, normalize and round registers in turn to the done strobe.
// Throughput: one word per cycle; busy is low outside reset, results are never held off.
// Reset: synchronous rst clears all valid bits; words in flight are dropped.
module int_to_float_convert (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode,
  input  logic                            truncate,
  input  logic [ictf_pkg::ValueW-1:0]     value,
  output logic                            done,
  output logic [ictf_pkg::ValueW-1:0]     result_bits
);
  import ictf_pkg::*;

  logic              in_valid;
  mode_t             mode_q;
  logic              trunc_q;
  logic [ValueW-1:0] value_q;
  logic              mid_valid;
  norm_t             mid_word;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    mode_q  <= mode_t'(mode);
    trunc_q <= truncate;
    value_q <= value;
  end

  ictf_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .mode      (mode_q),
    .trunc     (trunc_q),
    .value     (value_q),
    .out_valid (mid_valid),
    .out_word  (mid_word)
  );

  ictf_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_word   (mid_word),
    .out_valid (done),
    .out_bits  (result_bits)
  );

endmodule

### rtl/ictf_norm.sv
// Normalize stage: sign, magnitude and leading-one position, registered.
// Depends on ictf_pkg.
module ictf_norm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  ictf_pkg::mode_t                 mode,
  input  logic                            trunc,
  input  logic [ictf_pkg::ValueW-1:0]     value,
  output logic                            out_valid,
  output ictf_pkg::norm_t                 out_word
);
  import ictf_pkg::*;

  logic        is32;
  logic [31:0] w32;
  logic [31:0] mag32;
  logic [ValueW-1:0] mag64;
  norm_t       word_next;

  always_comb begin
    is32  = (mode == MODE_I32_SGL) || (mode == MODE_I32_DBL);
    w32   = value[31:0];
    mag32 = w32[31] ? (~w32 + 32'd1) : w32;
    mag64 = value[ValueW-1] ? (~value + ValueW'(1)) : value;

    word_next.dbl   = (mode == MODE_I32_DBL) || (mode == MODE_I64_DBL);
    word_next.trunc = trunc;
    word_next.neg   = is32 ? w32[31] : value[ValueW-1];
    word_next.mag   = is32 ? {32'd0, mag32} : mag64;
    word_next.zero  = (word_next.mag == '0);
    word_next.lead  = lead_one(word_next.mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= word_next;
  end

endmodule

### rtl/ictf_round.sv
// Round stage: aligns the fraction, rounds (or truncates when trunc is set), packs single or double, registered.
// Depends on ictf_pkg.
module ictf_round (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  ictf_pkg::norm_t                 in_word,
  output logic                            out_valid,
  output logic [ictf_pkg::ValueW-1:0]     out_bits
);
  import ictf_pkg::*;

  logic [ValueW-1:0]  norm;
  logic [DblExpW-1:0] dexp;
  logic [SglExpW-1:0] sexp;
  logic               dup;
  logic               sup;
  logic [ValueW-1:0]  dbits;
  logic [SglW-1:0]    sbits;
  logic [ValueW-1:0]  bits_next;

  always_comb begin
    // leading one moved to the top bit
    norm = in_word.mag << (LeadW'(ValueW - 1) - in_word.lead);

    dup = !in_word.trunc && norm[10] && ((|norm[9:0]) || norm[11]);
    sup = !in_word.trunc && norm[39] && ((|norm[38:0]) || norm[40]);

    dexp = DblExpW'(DblBias - 1) + DblExpW'(in_word.lead);
    sexp = SglExpW'(SglBias - 1) + SglExpW'(in_word.lead);

    // hidden bit and rounding carry both fold into the exponent field
    dbits = {1'b0, dexp, {DblMant{1'b0}}} + {11'd0, norm[63:11]} + ValueW'(dup);
    sbits = {1'b0, sexp, {SglMant{1'b0}}} + {8'd0, norm[63:40]} + SglW'(sup);

    if (in_word.zero) begin
      bits_next = '0;
    end else if (in_word.dbl) begin
      bits_next = {in_word.neg, dbits[ValueW-2:0]};
    end else begin
      bits_next = {32'd0, in_word.neg, sbits[SglW-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_bits <= bits_next;
  end

endmodule
